### sv/record_sort_by_key_descending_defines.svh
// Assertion macros for the descending record sort.
// Included by the top level; relies on nothing else.
`ifndef RECORD_SORT_BY_KEY_DESCENDING_DEFINES_SVH
`define RECORD_SORT_BY_KEY_DESCENDING_DEFINES_SVH

// Check that cons holds whenever ante holds, in the same cycle.
`define RSK_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define RSK_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/rsk_pkg.sv
// Types and codes shared by the record sort cells and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rsk_pkg;

    typedef struct packed {
        logic [15:0] score_key;
        logic [6:0]  age_value;
        logic [7:0]  record_handle;
        logic        final_record;
    } in_word_t;

    typedef struct packed {
        logic [15:0] sorted_key;
        logic [6:0]  sorted_age;
        logic [7:0]  sorted_handle;
        logic        run_end;
        logic        overflow_flag;
    } out_word_t;

    typedef struct packed {
        logic [15:0] key;
        logic [6:0]  age;
        logic [7:0]  handle;
    } rec_t;

    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_SHIFT  = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        rec_t       new_rec;
    } cell_ctl_t;

endpackage

`default_nettype wire

### sv/record_sort_by_key_descending.sv
// Channel  | Dir | Type        | Handshake
// s_word   | in  | in_word_t   | s_valid / s_ready
// m_word   | out | out_word_t  | m_valid / m_ready
//
// A record is placed in the cell chain in the cycle it is accepted, one per cycle
// while idle; when the store is full it is dropped. After a word marked final,
// the chain shifts one record per cycle into the output register while the
// output is not stalled. No input is taken while a set drains; input reopens
// the cycle after the count reaches zero. Reset (aresetn, synchronous) empties
// the store; cell contents need no clearing. A stalled result holds the chain.
`include "record_sort_by_key_descending_defines.svh"
`timescale 1ns / 1ps
`default_nettype none

module record_sort_by_key_descending #(
    parameter int CAPACITY = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire rsk_pkg::in_word_t  s_word,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output rsk_pkg::out_word_t      m_word
);
    import rsk_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic             state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             drop_reg, drop_next;
    logic             ovf_reg, ovf_next;
    logic             m_valid_reg, m_valid_next;
    out_word_t        out_reg, out_next;

    cell_ctl_t        ctl;
    rec_t             cell_rec  [CAPACITY];
    logic             cell_take [CAPACITY];

    logic in_acc, full, load;

    assign s_ready = (state_reg == ST_IDLE);
    assign in_acc  = s_valid && s_ready;
    assign full    = (cnt_reg == CNT_W'(CAPACITY));
    assign load    = (state_reg == ST_EMIT) && (cnt_reg != '0)
                     && (!m_valid_reg || m_ready);

    always_comb begin
        ctl.new_rec.key    = s_word.score_key;
        ctl.new_rec.age    = s_word.age_value;
        ctl.new_rec.handle = s_word.record_handle;
        if (in_acc && !full) begin
            ctl.op = OP_INSERT;
        end else if (load) begin
            ctl.op = OP_SHIFT;
        end else begin
            ctl.op = OP_HOLD;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        rsk_cell u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .occupied  (CNT_W'(i) < cnt_reg),
            .left_rec  ((i == 0) ? ctl.new_rec : cell_rec[(i == 0) ? 0 : i - 1]),
            .left_take ((i == 0) ? 1'b0 : cell_take[(i == 0) ? 0 : i - 1]),
            .right_rec (cell_rec[(i == CAPACITY - 1) ? i : i + 1]),
            .rec       (cell_rec[i]),
            .take      (cell_take[i])
        );
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        drop_next    = drop_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (!full) begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    if (s_word.final_record) begin
                        state_next = ST_EMIT;
                        ovf_next   = drop_reg || full;
                        drop_next  = 1'b0;
                    end else if (full) begin
                        drop_next = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (cnt_reg == '0) begin
                    state_next = ST_IDLE;
                end else if (load) begin
                    // advance the head record into the output word
                    out_next.sorted_key    = cell_rec[0].key;
                    out_next.sorted_age    = cell_rec[0].age;
                    out_next.sorted_handle = cell_rec[0].handle;
                    out_next.run_end       = (cnt_reg == CNT_W'(1));
                    out_next.overflow_flag = ovf_reg;
                    m_valid_next           = 1'b1;
                    cnt_next               = cnt_reg - CNT_W'(1);
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            drop_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            drop_reg    <= drop_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = out_reg;

    `RSK_ASSERT_NOW(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(CAPACITY), "store count above capacity")
    `RSK_ASSERT_NEXT(a_end_drained, aclk, aresetn, load && cnt_reg == CNT_W'(1), cnt_reg == '0 && m_valid && m_word.run_end, "last word of set not marked")
    `RSK_ASSERT_NEXT(a_descending, aclk, aresetn, m_valid && m_ready && !m_word.run_end, !m_valid || m_word.sorted_key <= $past(m_word.sorted_key), "keys out of descending order")

endmodule

`default_nettype wire

### sv/rsk_cell.sv
// One cell of the sorting chain: holds one record, takes the arriving
// record or its left neighbor's on insert, its right neighbor's on shift.
// Depends on rsk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsk_cell (
    input  wire logic             aclk,
    input  wire rsk_pkg::cell_ctl_t ctl,
    input  wire logic             occupied,
    input  wire rsk_pkg::rec_t    left_rec,
    input  wire logic             left_take,
    input  wire rsk_pkg::rec_t    right_rec,
    output rsk_pkg::rec_t         rec,
    output logic                  take
);
    import rsk_pkg::*;

    rec_t rec_reg;
    rec_t rec_next;

    // strict compare keeps equal keys in arrival order
    assign take = (ctl.op == OP_INSERT)
                  && (!occupied || (ctl.new_rec.key > rec_reg.key));
    assign rec  = rec_reg;

    always_comb begin
        rec_next = rec_reg;
        unique case (ctl.op)
            OP_INSERT: begin
                if (take) begin
                    rec_next = left_take ? left_rec : ctl.new_rec;
                end
            end
            OP_SHIFT: rec_next = right_rec;
            default:  rec_next = rec_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

endmodule

`default_nettype wire
